// ===== hdl/ctfsm_pkg.sv =====
`timescale 1ns / 1ps
package ctfsm_pkg;

  typedef enum logic [2:0] {
    K_OPEN       = 3'd0,
    K_CONNECT    = 3'd1,
    K_DISCONNECT = 3'd2,
    K_CLOSE      = 3'd3,
    K_SEGMENT    = 3'd4,
    K_TICK       = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CLOSED    = 2'd0,
    SYNSENT   = 2'd1,
    CONNECTED = 2'd2,
    FINWAIT   = 2'd3
  } conn_e;

  localparam logic [1:0] SYN    = 2'd0;
  localparam logic [1:0] SYNACK = 2'd1;
  localparam logic [1:0] FIN    = 2'd2;
  localparam logic [1:0] FINACK = 2'd3;

  typedef enum logic [3:0] {
    EV_NOTHING      = 4'd0,
    EV_SEND         = 4'd1,
    EV_OPENED       = 4'd2,
    EV_TABLE_FULL   = 4'd3,
    EV_CONNECTED    = 4'd4,
    EV_CONN_FAIL    = 4'd5,
    EV_DISCONNECTED = 4'd6,
    EV_DISC_FAIL    = 4'd7,
    EV_CLOSED       = 4'd8,
    EV_REFUSED      = 4'd9,
    EV_NO_MATCH     = 4'd10
  } event_e;

  typedef enum logic [1:0] {
    REG_SYN_TIMEOUT = 2'd0,
    REG_SYN_RETRY   = 2'd1,
    REG_FIN_TIMEOUT = 2'd2,
    REG_FIN_RETRY   = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_READ  = 2'd1,
    S_EVAL  = 2'd2,
    S_FLUSH = 2'd3
  } seq_state_e;

  localparam int MAX_RESULTS = 8;

  localparam logic [23:0] SYN_TIMEOUT_RST = 24'd1000;
  localparam logic [3:0]  SYN_RETRY_RST   = 4'd5;
  localparam logic [23:0] FIN_TIMEOUT_RST = 24'd1000;
  localparam logic [3:0]  FIN_RETRY_RST   = 4'd5;

  typedef struct packed {
    logic [23:0] syn_tmo;
    logic [3:0]  syn_retry;
    logic [23:0] fin_tmo;
    logic [3:0]  fin_retry;
  } cfg_t;

  typedef struct packed {
    event_e      ev;
    logic [2:0]  id;
    logic [1:0]  typ;
    logic [15:0] src;
    logic [15:0] dst;
    logic [9:0]  seq;
  } res_t;

endpackage

// ===== hdl/ctfsm_cfg.sv =====
`timescale 1ns / 1ps
module ctfsm_cfg
  import ctfsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_SYN_TIMEOUT: cfg_d.syn_tmo   = cfg_data_i;
        REG_SYN_RETRY:   cfg_d.syn_retry = cfg_data_i[3:0];
        REG_FIN_TIMEOUT: cfg_d.fin_tmo   = cfg_data_i;
        REG_FIN_RETRY:   cfg_d.fin_retry = cfg_data_i[3:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.syn_tmo   <= SYN_TIMEOUT_RST;
      cfg_q.syn_retry <= SYN_RETRY_RST;
      cfg_q.fin_tmo   <= FIN_TIMEOUT_RST;
      cfg_q.fin_retry <= FIN_RETRY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/connection_table_handshake_fsm_top.sv =====
`timescale 1ns / 1ps
// Connection table with a per-entry handshake state machine.
// Command channel: kind_i, socket_id_i, port_i, seg_type_i are taken at a clock
// edge with start high and busy low. busy stays high until the command is done.
// Results leave on event_res_o .. seq_num_o for one cycle each, marked by
// res_valid_o; last_o flags the final result of a command. The receiver has no
// backpressure; every result must be captured in its strobe cycle.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high, write only while busy is low.
// One sequencer walks the entries: per visited entry a read state (registered
// read of the port/sequence memory), then an evaluation state (shared timer/
// compare unit); a flush state ends the command. Connect, disconnect and close
// visit only the addressed entry; open and segment walk from entry 0 to a match
// or the last entry; a tick visits every entry. The last result is on the ports
// in the first cycle with busy low, when the next command may already be taken.
// Reset clears the entry flags, states, counters, timers and the
// config registers to their defaults; the port/sequence memory is not cleared.
module connection_table_handshake_fsm_top
  import ctfsm_pkg::*;
#(
  parameter int NUM_ENTRIES = 8,
  parameter int SEQ_MODULUS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [2:0]  socket_id_i,
  input  logic [15:0] port_i,
  input  logic [1:0]  seg_type_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output logic        res_valid_o,
  output logic [3:0]  event_res_o,
  output logic [2:0]  entry_id_o,
  output logic [1:0]  out_type_o,
  output logic [15:0] src_port_o,
  output logic [15:0] dst_port_o,
  output logic [9:0]  seq_num_o,
  output logic        last_o
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int SEQ_W = $clog2(SEQ_MODULUS);
  localparam int MEM_W = 32 + SEQ_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
  localparam logic [SEQ_W-1:0] SEQ_MAX  = SEQ_W'(SEQ_MODULUS - 1);

  cfg_t cfg;

  ctfsm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    seq_inc = (s == SEQ_MAX) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SEQ_W-1:0] seq_dec(input logic [SEQ_W-1:0] s);
    seq_dec = (s == '0) ? SEQ_MAX : s - 1'b1;
  endfunction

  seq_state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  kind_e       kind_q;
  logic [2:0]  sid_q;
  logic [15:0] port_q;
  logic [1:0]  stype_q;
  logic [3:0]  cnt_q, cnt_d;
  logic        pend_q, pend_d;
  res_t        pres_q, pres_d;

  logic        used_q  [NUM_ENTRIES];
  conn_e       st_q    [NUM_ENTRIES];
  logic [3:0]  sent_q  [NUM_ENTRIES];
  logic [23:0] tmr_q   [NUM_ENTRIES];

  logic [MEM_W-1:0] mem_q [NUM_ENTRIES];
  logic [MEM_W-1:0] rd_q;
  logic             mem_we;
  logic [MEM_W-1:0] mem_wd;

  logic        ent_we;
  logic        used_w;
  conn_e       st_w;
  logic [3:0]  sent_w;
  logic [23:0] tmr_w;

  logic        new_res;
  res_t        nres;
  logic        emit, emit_last;
  res_t        out_q;
  logic        out_valid_q, out_last_q;

  logic [15:0]      rd_lport, rd_rport;
  logic [SEQ_W-1:0] rd_seq;
  logic             sid_ok, ent_valid, cur_used, syn;
  conn_e            cur_st;
  logic [3:0]       cur_sent, lim;
  logic [23:0]      cur_tmr;

  assign rd_lport = rd_q[MEM_W-1 -: 16];
  assign rd_rport = rd_q[SEQ_W +: 16];
  assign rd_seq   = rd_q[SEQ_W-1:0];

  assign sid_ok    = 32'(sid_q) < NUM_ENTRIES;
  assign cur_used  = used_q[idx_q];
  assign cur_st    = st_q[idx_q];
  assign cur_sent  = sent_q[idx_q];
  assign cur_tmr   = tmr_q[idx_q];
  assign ent_valid = sid_ok && cur_used;
  assign syn       = (cur_st == SYNSENT);
  assign lim       = syn ? cfg.syn_retry : cfg.fin_retry;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    pres_d    = pres_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    new_res   = 1'b0;
    nres      = '0;
    mem_we    = 1'b0;
    mem_wd    = rd_q;
    ent_we    = 1'b0;
    used_w    = cur_used;
    st_w      = cur_st;
    sent_w    = cur_sent;
    tmr_w     = cur_tmr;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cnt_d  = '0;
          pend_d = 1'b0;
          if (kind_i == K_CONNECT || kind_i == K_DISCONNECT || kind_i == K_CLOSE) begin
            idx_d = IDX_W'(socket_id_i);
          end else begin
            idx_d = '0;
          end
          state_d = (kind_i > K_TICK) ? S_FLUSH : S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_FLUSH;
        case (kind_q)
          K_OPEN: begin
            if (!cur_used) begin
              ent_we  = 1'b1;
              used_w  = 1'b1;
              st_w    = CLOSED;
              sent_w  = '0;
              tmr_w   = '0;
              mem_we  = 1'b1;
              mem_wd  = {port_q, 16'd0, {SEQ_W{1'b0}}};
              new_res = 1'b1;
              nres.ev = EV_OPENED;
              nres.id = 3'(idx_q);
            end else if (idx_q == LAST_IDX) begin
              new_res = 1'b1;
              nres.ev = EV_TABLE_FULL;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_READ;
            end
          end
          K_CONNECT: begin
            new_res = 1'b1;
            nres.id = sid_q;
            if (!ent_valid || cur_st != CLOSED) begin
              nres.ev = EV_REFUSED;
            end else begin
              ent_we   = 1'b1;
              st_w     = SYNSENT;
              sent_w   = 4'd1;
              tmr_w    = cfg.syn_tmo;
              mem_we   = 1'b1;
              mem_wd   = {rd_lport, port_q, seq_inc(rd_seq)};
              nres.ev  = EV_SEND;
              nres.typ = SYN;
              nres.src = rd_lport;
              nres.dst = port_q;
              nres.seq = 10'(rd_seq);
            end
          end
          K_DISCONNECT: begin
            new_res = 1'b1;
            nres.id = sid_q;
            if (!ent_valid || cur_st != CONNECTED) begin
              nres.ev = EV_REFUSED;
            end else begin
              ent_we   = 1'b1;
              st_w     = FINWAIT;
              sent_w   = 4'd1;
              tmr_w    = cfg.fin_tmo;
              mem_we   = 1'b1;
              mem_wd   = {rd_lport, rd_rport, seq_inc(rd_seq)};
              nres.ev  = EV_SEND;
              nres.typ = FIN;
              nres.src = rd_lport;
              nres.dst = rd_rport;
              nres.seq = 10'(rd_seq);
            end
          end
          K_CLOSE: begin
            new_res = 1'b1;
            nres.id = sid_q;
            if (!ent_valid || cur_st != CLOSED) begin
              nres.ev = EV_REFUSED;
            end else begin
              ent_we  = 1'b1;
              used_w  = 1'b0;
              sent_w  = '0;
              tmr_w   = '0;
              nres.ev = EV_CLOSED;
            end
          end
          K_SEGMENT: begin
            if (cur_used && rd_lport == port_q) begin
              new_res = 1'b1;
              nres.id = 3'(idx_q);
              if (cur_st == SYNSENT && stype_q == SYNACK) begin
                ent_we  = 1'b1;
                st_w    = CONNECTED;
                sent_w  = '0;
                tmr_w   = '0;
                nres.ev = EV_CONNECTED;
              end else if (cur_st == FINWAIT && stype_q == FINACK) begin
                ent_we  = 1'b1;
                st_w    = CLOSED;
                sent_w  = '0;
                tmr_w   = '0;
                nres.ev = EV_DISCONNECTED;
              end else begin
                nres.ev = EV_NOTHING;
              end
            end else if (idx_q == LAST_IDX) begin
              new_res = 1'b1;
              nres.ev = EV_NO_MATCH;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_READ;
            end
          end
          K_TICK: begin
            if (cur_used && (cur_st == SYNSENT || cur_st == FINWAIT)) begin
              ent_we = 1'b1;
              if (cur_tmr > 24'd1) begin
                tmr_w = cur_tmr - 1'b1;
              end else if (32'(cnt_q) >= MAX_RESULTS) begin
                tmr_w = 24'd1;
              end else if (cur_sent < lim) begin
                sent_w   = cur_sent + 1'b1;
                tmr_w    = syn ? cfg.syn_tmo : cfg.fin_tmo;
                new_res  = 1'b1;
                nres.ev  = EV_SEND;
                nres.id  = 3'(idx_q);
                nres.typ = syn ? SYN : FIN;
                nres.src = rd_lport;
                nres.dst = rd_rport;
                nres.seq = 10'(seq_dec(rd_seq));
              end else begin
                st_w    = CLOSED;
                sent_w  = '0;
                tmr_w   = '0;
                new_res = 1'b1;
                nres.ev = syn ? EV_CONN_FAIL : EV_DISC_FAIL;
                nres.id = 3'(idx_q);
              end
            end
            if (idx_q != LAST_IDX) begin
              idx_d   = idx_q + 1'b1;
              state_d = S_READ;
            end
          end
          default: state_d = S_FLUSH;
        endcase
      end
      S_FLUSH: begin
        emit      = pend_q;
        emit_last = 1'b1;
        pend_d    = 1'b0;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (new_res) begin
      emit   = pend_q;
      pend_d = 1'b1;
      pres_d = nres;
      cnt_d  = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= emit;
      out_last_q  <= emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      kind_q  <= kind_e'(kind_i);
      sid_q   <= socket_id_i;
      port_q  <= port_i;
      stype_q <= seg_type_i;
    end
    pres_q <= pres_d;
    if (emit) begin
      out_q <= pres_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        used_q[i] <= 1'b0;
        st_q[i]   <= CLOSED;
        sent_q[i] <= '0;
        tmr_q[i]  <= '0;
      end
    end else if (ent_we) begin
      used_q[idx_q] <= used_w;
      st_q[idx_q]   <= st_w;
      sent_q[idx_q] <= sent_w;
      tmr_q[idx_q]  <= tmr_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= mem_wd;
    end
    rd_q <= mem_q[idx_q];
  end

  assign res_valid_o = out_valid_q;
  assign event_res_o = out_q.ev;
  assign entry_id_o  = out_q.id;
  assign out_type_o  = out_q.typ;
  assign src_port_o  = out_q.src;
  assign dst_port_o  = out_q.dst;
  assign seq_num_o   = out_q.seq;
  assign last_o      = out_last_q;

endmodule

// ===== hdl/ctfsm_checker.sv =====
`timescale 1ns / 1ps
module ctfsm_checker
  import ctfsm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        res_valid_o,
  input logic [3:0]  event_res_o,
  input logic [1:0]  out_type_o,
  input logic [15:0] src_port_o,
  input logic [15:0] dst_port_o,
  input logic [9:0]  seq_num_o,
  input logic        last_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("command accepted but busy not raised");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |-> busy)
    else $error("non-final result after command completed");

  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> event_res_o <= EV_NO_MATCH)
    else $error("event code out of range");

  a_send_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && event_res_o != EV_SEND |->
      out_type_o == 2'd0 && src_port_o == 16'd0 && dst_port_o == 16'd0 && seq_num_o == 10'd0)
    else $error("segment fields set on a non-send result");

endmodule

bind connection_table_handshake_fsm_top ctfsm_checker u_ctfsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .event_res_o (event_res_o),
  .out_type_o  (out_type_o),
  .src_port_o  (src_port_o),
  .dst_port_o  (dst_port_o),
  .seq_num_o   (seq_num_o),
  .last_o      (last_o)
);
